// ===== sv/udpdmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package udpdmx_pkg;
	localparam int NUM_PORTS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int NUM_RAW_DEF = 4;

	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [12:0] ETH_HDR = 13'd14;
	localparam logic [12:0] MIN_UDP_FRAME = 13'd42;

	localparam logic [2:0] REQ_BIND_PORT = 3'd0;
	localparam logic [2:0] REQ_BIND_RAW = 3'd1;
	localparam logic [2:0] REQ_DELIVER = 3'd2;
	localparam logic [2:0] REQ_DEQ_UDP = 3'd3;
	localparam logic [2:0] REQ_DEQ_RAW = 3'd4;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_QUEUED = 4'd1;
	localparam logic [3:0] ST_RAW_FULL = 4'd2;
	localparam logic [3:0] ST_NOT_UDP = 4'd3;
	localparam logic [3:0] ST_SHORT = 4'd4;
	localparam logic [3:0] ST_UNBOUND = 4'd5;
	localparam logic [3:0] ST_PORT_FULL = 4'd6;
	localparam logic [3:0] ST_TABLE_FULL = 4'd7;
	localparam logic [3:0] ST_NOT_BOUND = 4'd8;
	localparam logic [3:0] ST_EMPTY = 4'd9;
	localparam logic [3:0] ST_BAD_ID = 4'd10;

	// classified work handed from front to back
	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  sock_index;
		logic        wr_udp;
		logic        wr_raw;
		logic        rd_udp;
		logic        rd_raw;
		logic [5:0]  pslot;
		logic [2:0]  raw_idx;
		logic [9:0]  ptr;
		logic [31:0] src_ip;
		logic [15:0] sender_port;
		logic [15:0] len;
		logic [7:0]  proto;
		logic [15:0] max_len;
	} op_t;
endpackage
`default_nettype wire

// ===== sv/udp_raw_receive_demux_queues.sv =====
// A result is registered first in the classify stage and then in the descriptor memory read,
// and is taken by the receiver from there.
// Busy holds for the cycle after a start so the pointer tables and the descriptor memory
// port each see one access per word; a new request can be taken while the last is still in the back.
// The receiver cannot stall; strobe marks each result for one cycle.
// Reset clears the bind tables and ring pointers; descriptor memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module udp_raw_receive_demux_queues #(
	parameter int NUM_PORTS = udpdmx_pkg::NUM_PORTS_DEF,
	parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_RAW = udpdmx_pkg::NUM_RAW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] port_num,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [2:0]  raw_sock_id,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] sender_port,
	input  wire logic [15:0] udp_length,
	input  wire logic [12:0] frame_length,
	input  wire logic [15:0] max_len,
	output logic             strobe,
	output logic [3:0]       status,
	output logic [1:0]       sock_index,
	output logic [31:0]      out_src_ip,
	output logic [15:0]      out_src_port,
	output logic [15:0]      data_len,
	output logic [7:0]       out_protocol
);
	logic take, busy_q, go_q;
	udpdmx_pkg::op_t op;

	assign take = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; go_q <= 1'b0;
		end else begin
			busy_q <= take;
			go_q <= take;
		end
	end

	udpdmx_front #(.NUM_PORTS(NUM_PORTS), .QUEUE_DEPTH(QUEUE_DEPTH), .NUM_RAW(NUM_RAW))
	u_front (
		.clk, .arst_n, .take, .req_type, .port_num, .ip_protocol, .raw_sock_id,
		.src_ip, .sender_port, .udp_length, .frame_length, .max_len, .op
	);

	udpdmx_back #(.NUM_PORTS(NUM_PORTS), .QUEUE_DEPTH(QUEUE_DEPTH), .NUM_RAW(NUM_RAW))
	u_back (
		.clk, .arst_n, .go(go_q), .op, .done(strobe), .status, .sock_index,
		.out_src_ip, .out_src_port, .data_len, .out_protocol
	);
endmodule
`default_nettype wire

// ===== sv/udpdmx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module udpdmx_front #(
	parameter int NUM_PORTS = udpdmx_pkg::NUM_PORTS_DEF,
	parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_RAW = udpdmx_pkg::NUM_RAW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] port_num,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [2:0]  raw_sock_id,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] sender_port,
	input  wire logic [15:0] udp_length,
	input  wire logic [12:0] frame_length,
	input  wire logic [15:0] max_len,
	output udpdmx_pkg::op_t  op
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int RW = (NUM_RAW > 1) ? $clog2(NUM_RAW) : 1;

	logic [NUM_PORTS-1:0] pvalid_q;
	logic [15:0] pnum_q [NUM_PORTS];
	logic [QW-1:0] phead_q [NUM_PORTS];
	logic [QW-1:0] ptail_q [NUM_PORTS];
	logic [FW-1:0] pfill_q [NUM_PORTS];
	logic [NUM_RAW-1:0] rvalid_q;
	logic [7:0] rproto_q [NUM_RAW];
	logic [QW-1:0] rhead_q [NUM_RAW];
	logic [QW-1:0] rtail_q [NUM_RAW];
	logic [FW-1:0] rfill_q [NUM_RAW];

	logic p_hit, p_free, r_hit, r_free;
	logic [PW-1:0] p_hidx, p_fidx;
	logic [RW-1:0] r_hidx, r_fidx, rid;
	logic rid_ok;
	logic bind_p, bind_r;
	udpdmx_pkg::op_t op_d;

	function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
		return (32'(p) + 32'd1 == 32'(QUEUE_DEPTH)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		p_hit = 1'b0; p_free = 1'b0; p_hidx = '0; p_fidx = '0;
		for (int i = NUM_PORTS - 1; i >= 0; i--) begin
			if (pvalid_q[i] && pnum_q[i] == port_num) begin
				p_hit = 1'b1; p_hidx = PW'(i);
			end
			if (!pvalid_q[i]) begin
				p_free = 1'b1; p_fidx = PW'(i);
			end
		end
		r_hit = 1'b0; r_free = 1'b0; r_hidx = '0; r_fidx = '0;
		for (int i = NUM_RAW - 1; i >= 0; i--) begin
			if (rvalid_q[i] && rproto_q[i] == ip_protocol) begin
				r_hit = 1'b1; r_hidx = RW'(i);
			end
			if (!rvalid_q[i]) begin
				r_free = 1'b1; r_fidx = RW'(i);
			end
		end
		rid_ok = {29'd0, raw_sock_id} < NUM_RAW;
		rid = RW'(raw_sock_id);
	end

	// classify the request word
	always_comb begin
		op_d = '0;
		op_d.status = udpdmx_pkg::ST_BAD_ID;
		op_d.pslot = 6'(p_hidx);
		op_d.raw_idx = 3'(r_hidx);
		op_d.src_ip = src_ip;
		op_d.sender_port = sender_port;
		op_d.proto = ip_protocol;
		op_d.max_len = max_len;
		bind_p = 1'b0;
		bind_r = 1'b0;
		case (req_type)
			udpdmx_pkg::REQ_BIND_PORT: begin
				if (p_hit) op_d.status = udpdmx_pkg::ST_OK;
				else if (p_free) begin
					op_d.status = udpdmx_pkg::ST_OK;
					bind_p = 1'b1;
				end else op_d.status = udpdmx_pkg::ST_TABLE_FULL;
			end
			udpdmx_pkg::REQ_BIND_RAW: begin
				if (r_hit) begin
					op_d.status = udpdmx_pkg::ST_OK;
					op_d.sock_index = 2'(r_hidx);
				end else if (r_free) begin
					op_d.status = udpdmx_pkg::ST_OK;
					op_d.sock_index = 2'(r_fidx);
					bind_r = 1'b1;
				end else op_d.status = udpdmx_pkg::ST_TABLE_FULL;
			end
			udpdmx_pkg::REQ_DELIVER: begin
				if (r_hit) begin
					op_d.sock_index = 2'(r_hidx);
					if (rfill_q[r_hidx] < FW'(QUEUE_DEPTH)) begin
						op_d.status = udpdmx_pkg::ST_QUEUED;
						op_d.wr_raw = 1'b1;
						op_d.ptr = 10'(rtail_q[r_hidx]);
						op_d.len = (frame_length > udpdmx_pkg::ETH_HDR) ?
							16'(frame_length - udpdmx_pkg::ETH_HDR) : 16'd0;
					end else op_d.status = udpdmx_pkg::ST_RAW_FULL;
				end else if (ip_protocol != udpdmx_pkg::PROTO_UDP)
					op_d.status = udpdmx_pkg::ST_NOT_UDP;
				else if (frame_length < udpdmx_pkg::MIN_UDP_FRAME)
					op_d.status = udpdmx_pkg::ST_SHORT;
				else if (!p_hit) op_d.status = udpdmx_pkg::ST_UNBOUND;
				else if (pfill_q[p_hidx] >= FW'(QUEUE_DEPTH))
					op_d.status = udpdmx_pkg::ST_PORT_FULL;
				else begin
					op_d.status = udpdmx_pkg::ST_QUEUED;
					op_d.wr_udp = 1'b1;
					op_d.ptr = 10'(ptail_q[p_hidx]);
					op_d.len = (udp_length > 16'd8) ? udp_length - 16'd8 : 16'd0;
				end
			end
			udpdmx_pkg::REQ_DEQ_UDP: begin
				if (!p_hit) op_d.status = udpdmx_pkg::ST_NOT_BOUND;
				else if (pfill_q[p_hidx] == '0) op_d.status = udpdmx_pkg::ST_EMPTY;
				else begin
					op_d.status = udpdmx_pkg::ST_OK;
					op_d.rd_udp = 1'b1;
					op_d.ptr = 10'(phead_q[p_hidx]);
				end
			end
			udpdmx_pkg::REQ_DEQ_RAW: begin
				op_d.raw_idx = 3'(rid);
				if (!rid_ok) op_d.status = udpdmx_pkg::ST_BAD_ID;
				else if (!rvalid_q[rid]) op_d.status = udpdmx_pkg::ST_NOT_BOUND;
				else if (rfill_q[rid] == '0) op_d.status = udpdmx_pkg::ST_EMPTY;
				else begin
					op_d.status = udpdmx_pkg::ST_OK;
					op_d.rd_raw = 1'b1;
					op_d.ptr = 10'(rhead_q[rid]);
				end
			end
			default: op_d.status = udpdmx_pkg::ST_BAD_ID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
			rvalid_q <= '0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				pnum_q[i] <= '0; phead_q[i] <= '0; ptail_q[i] <= '0; pfill_q[i] <= '0;
			end
			for (int i = 0; i < NUM_RAW; i++) begin
				rproto_q[i] <= '0; rhead_q[i] <= '0; rtail_q[i] <= '0; rfill_q[i] <= '0;
			end
			op <= '0;
		end else begin
			if (take) op <= op_d;
			else begin
				op.wr_udp <= 1'b0; op.wr_raw <= 1'b0;
				op.rd_udp <= 1'b0; op.rd_raw <= 1'b0;
			end
			if (take) begin
				if (bind_p) begin
					pvalid_q[p_fidx] <= 1'b1;
					pnum_q[p_fidx] <= port_num;
					phead_q[p_fidx] <= '0; ptail_q[p_fidx] <= '0;
					pfill_q[p_fidx] <= '0;
				end else if (bind_r) begin
					rvalid_q[r_fidx] <= 1'b1;
					rproto_q[r_fidx] <= ip_protocol;
					rhead_q[r_fidx] <= '0; rtail_q[r_fidx] <= '0;
					rfill_q[r_fidx] <= '0;
				end else if (op_d.wr_raw) begin
					rtail_q[r_hidx] <= ring_next(rtail_q[r_hidx]);
					rfill_q[r_hidx] <= rfill_q[r_hidx] + 1'b1;
				end else if (op_d.wr_udp) begin
					ptail_q[p_hidx] <= ring_next(ptail_q[p_hidx]);
					pfill_q[p_hidx] <= pfill_q[p_hidx] + 1'b1;
				end else if (op_d.rd_udp) begin
					phead_q[p_hidx] <= ring_next(phead_q[p_hidx]);
					pfill_q[p_hidx] <= pfill_q[p_hidx] - 1'b1;
				end else if (op_d.rd_raw) begin
					rhead_q[rid] <= ring_next(rhead_q[rid]);
					rfill_q[rid] <= rfill_q[rid] - 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/udpdmx_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module udpdmx_back #(
	parameter int NUM_PORTS = udpdmx_pkg::NUM_PORTS_DEF,
	parameter int QUEUE_DEPTH = udpdmx_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_RAW = udpdmx_pkg::NUM_RAW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  udpdmx_pkg::op_t  op,
	output logic             done,
	output logic [3:0]       status,
	output logic [1:0]       sock_index,
	output logic [31:0]      out_src_ip,
	output logic [15:0]      out_src_port,
	output logic [15:0]      data_len,
	output logic [7:0]       out_protocol
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int RW = (NUM_RAW > 1) ? $clog2(NUM_RAW) : 1;

	logic [63:0] udp_mem [NUM_PORTS*QUEUE_DEPTH];
	logic [55:0] raw_mem [NUM_RAW*QUEUE_DEPTH];
	logic [63:0] udp_rd_q;
	logic [55:0] raw_rd_q;
	logic [PW+QW-1:0] uaddr;
	logic [RW+QW-1:0] raddr;

	assign uaddr = {op.pslot[PW-1:0], op.ptr[QW-1:0]};
	assign raddr = {op.raw_idx[RW-1:0], op.ptr[QW-1:0]};

	// memory port, written on a go, read at the same address every cycle
	always_ff @(posedge clk) begin
		if (go && op.wr_udp) udp_mem[uaddr] <= {op.src_ip, op.sender_port, op.len};
		if (go && op.wr_raw) raw_mem[raddr] <= {op.src_ip, op.len, op.proto};
		udp_rd_q <= udp_mem[uaddr];
		raw_rd_q <= raw_mem[raddr];
	end

	logic go_q;
	logic [3:0] st_q;
	logic [1:0] si_q;
	logic rdu_q, rdr_q;
	logic [15:0] ml_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
			rdu_q <= 1'b0; rdr_q <= 1'b0;
		end else begin
			go_q <= go;
			rdu_q <= go && op.rd_udp;
			rdr_q <= go && op.rd_raw;
		end
	end
	always_ff @(posedge clk) begin
		st_q <= op.status; si_q <= op.sock_index; ml_q <= op.max_len;
	end

	always_comb begin
		done = go_q;
		status = st_q;
		sock_index = si_q;
		out_src_ip = '0; out_src_port = '0; data_len = '0; out_protocol = '0;
		if (rdu_q) begin
			out_src_ip = udp_rd_q[63:32];
			out_src_port = udp_rd_q[31:16];
			data_len = (udp_rd_q[15:0] < ml_q) ? udp_rd_q[15:0] : ml_q;
		end else if (rdr_q) begin
			out_src_ip = raw_rd_q[55:24];
			data_len = (raw_rd_q[23:8] < ml_q) ? raw_rd_q[23:8] : ml_q;
			out_protocol = raw_rd_q[7:0];
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/udp_raw_receive_demux_queues_check.sv =====
`timescale 1ns / 1ps
module udp_raw_receive_demux_queues_check #(
	parameter int NP = 16,
	parameter int QD = 128,
	parameter int NR = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] port_num,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [2:0]  raw_sock_id,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] sender_port,
	input  wire logic [15:0] udp_length,
	input  wire logic [12:0] frame_length,
	input  wire logic [15:0] max_len,
	input  wire logic        strobe,
	input  wire logic [3:0]  status,
	input  wire logic [1:0]  sock_index,
	input  wire logic [31:0] out_src_ip,
	input  wire logic [15:0] out_src_port,
	input  wire logic [15:0] data_len,
	input  wire logic [7:0]  out_protocol,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  sock_index;
		logic [31:0] src_ip;
		logic [15:0] sport;
		logic [15:0] data_len;
		logic [7:0]  protocol;
	} reply_t;

	reply_t replies_due[$];
	int errs;

	bit          port_bound[NP];
	logic [15:0] port_id[NP];
	int          port_rd[NP], port_wr[NP], port_cnt[NP];
	logic [31:0] udp_ip[NP][QD];
	logic [15:0] udp_sport[NP][QD], udp_len[NP][QD];

	bit          raw_bound[NR];
	logic [7:0]  raw_proto[NR];
	int          raw_rd[NR], raw_wr[NR], raw_cnt[NR];
	logic [31:0] raw_ip[NR][QD];
	logic [15:0] raw_len[NR][QD];
	logic [7:0]  raw_pr[NR][QD];

	function automatic int port_lookup(logic [15:0] p);
		for (int i = 0; i < NP; i++)
			if (port_bound[i] && port_id[i] == p) return i;
		return -1;
	endfunction

	function automatic int raw_lookup(logic [7:0] p);
		for (int i = 0; i < NR; i++)
			if (raw_bound[i] && raw_proto[i] == p) return i;
		return -1;
	endfunction

	function automatic logic [15:0] clip(logic [15:0] a, logic [15:0] b);
		return (a < b) ? a : b;
	endfunction

	task automatic demux_request(output reply_t r);
		int i;
		r = '0;
		r.status = udpdmx_pkg::ST_BAD_ID;
		case (req_type)
			udpdmx_pkg::REQ_BIND_PORT: begin
				r.status = udpdmx_pkg::ST_OK;
				if (port_lookup(port_num) < 0) begin
					r.status = udpdmx_pkg::ST_TABLE_FULL;
					for (i = 0; i < NP; i++)
						if (!port_bound[i]) begin
							port_bound[i] = 1;
							port_id[i] = port_num;
							port_rd[i] = 0; port_wr[i] = 0; port_cnt[i] = 0;
							r.status = udpdmx_pkg::ST_OK;
							break;
						end
				end
			end
			udpdmx_pkg::REQ_BIND_RAW: begin
				i = raw_lookup(ip_protocol);
				if (i >= 0) begin
					r.status = udpdmx_pkg::ST_OK;
					r.sock_index = 2'(i);
				end else begin
					r.status = udpdmx_pkg::ST_TABLE_FULL;
					for (i = 0; i < NR; i++)
						if (!raw_bound[i]) begin
							raw_bound[i] = 1;
							raw_proto[i] = ip_protocol;
							raw_rd[i] = 0; raw_wr[i] = 0; raw_cnt[i] = 0;
							r.status = udpdmx_pkg::ST_OK;
							r.sock_index = 2'(i);
							break;
						end
				end
			end
			udpdmx_pkg::REQ_DELIVER: begin
				i = raw_lookup(ip_protocol);
				if (i >= 0) begin
					r.sock_index = 2'(i);
					if (raw_cnt[i] < QD) begin
						raw_ip[i][raw_wr[i]] = src_ip;
						raw_len[i][raw_wr[i]] = (frame_length > udpdmx_pkg::ETH_HDR) ?
							16'(frame_length - udpdmx_pkg::ETH_HDR) : 16'd0;
						raw_pr[i][raw_wr[i]] = ip_protocol;
						raw_wr[i] = (raw_wr[i] + 1) % QD;
						raw_cnt[i]++;
						r.status = udpdmx_pkg::ST_QUEUED;
					end else
						r.status = udpdmx_pkg::ST_RAW_FULL;
				end else if (ip_protocol != udpdmx_pkg::PROTO_UDP)
					r.status = udpdmx_pkg::ST_NOT_UDP;
				else if (frame_length < udpdmx_pkg::MIN_UDP_FRAME)
					r.status = udpdmx_pkg::ST_SHORT;
				else begin
					i = port_lookup(port_num);
					if (i < 0)
						r.status = udpdmx_pkg::ST_UNBOUND;
					else if (port_cnt[i] >= QD)
						r.status = udpdmx_pkg::ST_PORT_FULL;
					else begin
						udp_ip[i][port_wr[i]] = src_ip;
						udp_sport[i][port_wr[i]] = sender_port;
						udp_len[i][port_wr[i]] = (udp_length > 16'd8) ?
							udp_length - 16'd8 : 16'd0;
						port_wr[i] = (port_wr[i] + 1) % QD;
						port_cnt[i]++;
						r.status = udpdmx_pkg::ST_QUEUED;
					end
				end
			end
			udpdmx_pkg::REQ_DEQ_UDP: begin
				i = port_lookup(port_num);
				if (i < 0)
					r.status = udpdmx_pkg::ST_NOT_BOUND;
				else if (port_cnt[i] == 0)
					r.status = udpdmx_pkg::ST_EMPTY;
				else begin
					r.src_ip = udp_ip[i][port_rd[i]];
					r.sport = udp_sport[i][port_rd[i]];
					r.data_len = clip(udp_len[i][port_rd[i]], max_len);
					port_rd[i] = (port_rd[i] + 1) % QD;
					port_cnt[i]--;
					r.status = udpdmx_pkg::ST_OK;
				end
			end
			udpdmx_pkg::REQ_DEQ_RAW: begin
				i = int'(raw_sock_id);
				if (i >= NR)
					r.status = udpdmx_pkg::ST_BAD_ID;
				else if (!raw_bound[i])
					r.status = udpdmx_pkg::ST_NOT_BOUND;
				else if (raw_cnt[i] == 0)
					r.status = udpdmx_pkg::ST_EMPTY;
				else begin
					r.src_ip = raw_ip[i][raw_rd[i]];
					r.data_len = clip(raw_len[i][raw_rd[i]], max_len);
					r.protocol = raw_pr[i][raw_rd[i]];
					raw_rd[i] = (raw_rd[i] + 1) % QD;
					raw_cnt[i]--;
					r.status = udpdmx_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) begin
				port_bound[i] = 0; port_id[i] = '0;
				port_rd[i] = 0; port_wr[i] = 0; port_cnt[i] = 0;
			end
			for (int i = 0; i < NR; i++) begin
				raw_bound[i] = 0; raw_proto[i] = '0;
				raw_rd[i] = 0; raw_wr[i] = 0; raw_cnt[i] = 0;
			end
			replies_due.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (strobe) begin
				got = {status, sock_index, out_src_ip, out_src_port, data_len, out_protocol};
				if (replies_due.size() == 0) begin
					errs++;
					$display("%0t: unexpected word %h", $time, got);
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						errs++;
						$display("%0t: expected st=%0d idx=%0d ip=%h sp=%h len=%0d pr=%0d",
							$time, want.status, want.sock_index, want.src_ip,
							want.sport, want.data_len, want.protocol);
						$display("%0t: actual   st=%0d idx=%0d ip=%h sp=%h len=%0d pr=%0d",
							$time, got.status, got.sock_index, got.src_ip,
							got.sport, got.data_len, got.protocol);
					end
				end
			end
			if (start && !busy) begin
				demux_request(want);
				replies_due.push_back(want);
			end
			fail_count <= errs;
			pending <= replies_due.size();
		end
	end
endmodule

// ===== tb/sv/udp_raw_receive_demux_queues_test.sv =====
`timescale 1ns / 1ps
module udp_raw_receive_demux_queues_test;
	logic        clk = 0, arst_n = 0, start = 0;
	logic        busy, strobe;
	logic [2:0]  req_type = '0;
	logic [15:0] port_num = '0;
	logic [7:0]  ip_protocol = '0;
	logic [2:0]  raw_sock_id = '0;
	logic [31:0] src_ip = '0;
	logic [15:0] sender_port = '0, udp_length = '0, max_len = '0;
	logic [12:0] frame_length = 13'd64;
	logic [3:0]  status;
	logic [1:0]  sock_index;
	logic [31:0] out_src_ip;
	logic [15:0] out_src_port, data_len;
	logic [7:0]  out_protocol;
	int fail_count, pending, cycles = 0;

	udp_raw_receive_demux_queues dut (.*);
	udp_raw_receive_demux_queues_check chk (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic issue(logic [2:0] rq, logic [15:0] pn, logic [7:0] pr, logic [2:0] rid,
			logic [31:0] sip, logic [15:0] sp, logic [15:0] ul, logic [12:0] fl,
			logic [15:0] ml, int gap);
		req_type <= rq; port_num <= pn; ip_protocol <= pr; raw_sock_id <= rid;
		src_ip <= sip; sender_port <= sp; udp_length <= ul; frame_length <= fl;
		max_len <= ml;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_port();
		int k;
		k = $urandom_range(0, 19);
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		if (k == 0) return 16'd0;
		if (k == 1) return 16'hffff;
		return 16'(k * 1000 + 7);
	endfunction

	function automatic logic [7:0] pick_raw_proto(bit allow_udp);
		if (allow_udp && $urandom_range(0, 9) == 0) return udpdmx_pkg::PROTO_UDP;
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd6;
			3: return 8'd255;
			4: return 8'd47;
			default: return 8'd50;
		endcase
	endfunction

	function automatic logic [12:0] pick_frame();
		case ($urandom_range(0, 7))
			0: return 13'($urandom_range(34, 41));
			1: return 13'd42;
			2: return 13'd41;
			default: return 13'($urandom_range(42, 4096));
		endcase
	endfunction

	initial begin
		int gap, r;
		logic [2:0] rq;
		logic [15:0] pn;
		logic [7:0] pr;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: binds, rebinds, short, non-UDP and unbound drops, clipping, empties, bad ids
		issue(udpdmx_pkg::REQ_BIND_PORT, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, '0, 0);
		issue(udpdmx_pkg::REQ_BIND_PORT, 16'hffff, 8'd0, 3'd0, '0, '0, '0, 13'd64, '0, 1);
		issue(udpdmx_pkg::REQ_BIND_PORT, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, '0, 0);
		issue(udpdmx_pkg::REQ_BIND_RAW, 16'd0, 8'd255, 3'd0, '0, '0, '0, 13'd64, '0, 2);
		issue(udpdmx_pkg::REQ_BIND_RAW, 16'd0, 8'd255, 3'd0, '0, '0, '0, 13'd64, '0, 0);
		issue(udpdmx_pkg::REQ_BIND_RAW, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, '0, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'd0, udpdmx_pkg::PROTO_UDP, 3'd0, 32'h0a000001,
			16'd5, 16'd0, 13'd42, '0, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'hffff, udpdmx_pkg::PROTO_UDP, 3'd0, '0, '0,
			16'd100, 13'd41, '0, 3);
		issue(udpdmx_pkg::REQ_DELIVER, 16'hffff, udpdmx_pkg::PROTO_UDP, 3'd7, 32'hffffffff,
			16'hffff, 16'hffff, 13'd4096, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'hffff, udpdmx_pkg::PROTO_UDP, 3'd0, 32'h1, 16'h1,
			16'd9, 13'd100, '0, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'd0, 8'd6, 3'd0, '0, '0, 16'd50, 13'd100, '0, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'd7, udpdmx_pkg::PROTO_UDP, 3'd0, '0, '0, 16'd50,
			13'd100, '0, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'd0, 8'd255, 3'd0, 32'hdeadbeef, '0, '0, 13'd34,
			'0, 0);
		issue(udpdmx_pkg::REQ_DELIVER, 16'd0, 8'd0, 3'd0, 32'h12345678, '0, '0, 13'd4096,
			'0, 0);
		issue(udpdmx_pkg::REQ_DEQ_UDP, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'd0, 0);
		issue(udpdmx_pkg::REQ_DEQ_UDP, 16'hffff, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DEQ_UDP, 16'hffff, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'd3, 0);
		issue(udpdmx_pkg::REQ_DEQ_UDP, 16'hffff, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DEQ_UDP, 16'd9, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DEQ_RAW, 16'd0, 8'd0, 3'd7, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DEQ_RAW, 16'd0, 8'd0, 3'd3, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DEQ_RAW, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(udpdmx_pkg::REQ_DEQ_RAW, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, 16'hffff, 0);
		issue(3'd5, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, '0, 0);
		issue(3'd7, 16'd0, 8'd0, 3'd0, '0, '0, '0, 13'd64, '0, 1);

		// hold until the block has drained
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int n = 0; n < 1100; n++) begin
			gap = (n % 200 < 50) ? 0 : $urandom_range(0, 13);
			pn = pick_port();
			pr = ($urandom_range(0, 1) == 0) ? udpdmx_pkg::PROTO_UDP : pick_raw_proto(0);
			if ($urandom_range(0, 15) == 0) pr = 8'($urandom);
			r = $urandom_range(0, 99);
			if (n >= 300 && n < 450) begin
				// flood one port past its ring depth
				rq = udpdmx_pkg::REQ_DELIVER; pn = 16'd0; pr = udpdmx_pkg::PROTO_UDP;
			end else if (n >= 450 && n < 600) begin
				rq = udpdmx_pkg::REQ_DELIVER; pr = 8'd255;
			end else if (r < 10) rq = udpdmx_pkg::REQ_BIND_PORT;
			else if (r < 15) begin
				rq = udpdmx_pkg::REQ_BIND_RAW;
				pr = pick_raw_proto(n >= 1000);
			end else if (r < 52) rq = udpdmx_pkg::REQ_DELIVER;
			else if (r < 75) rq = udpdmx_pkg::REQ_DEQ_UDP;
			else if (r < 97) rq = udpdmx_pkg::REQ_DEQ_RAW;
			else rq = 3'($urandom_range(5, 7));
			issue(rq, pn, pr, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)),
				$urandom, 16'($urandom),
				($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 9)) : 16'($urandom),
				pick_frame(), 16'($urandom), gap);
		end
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/udpdmx_pkg.sv
sv/udpdmx_front.sv
sv/udpdmx_back.sv
sv/udp_raw_receive_demux_queues.sv
tb/sv/udp_raw_receive_demux_queues_check.sv
tb/sv/udp_raw_receive_demux_queues_test.sv
